// ===== design/cosine_sine_taylor_unit_assert.svh =====
// Assertion macros used by the cosine and sine unit checker.
`ifndef COSINE_SINE_TAYLOR_UNIT_ASSERT_SVH
`define COSINE_SINE_TAYLOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cstu_pkg.sv =====
// Types and fixed-point constants of the cosine and sine unit.
`default_nettype none

package cstu_pkg;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;

  // Angle constants scaled by 2^32 and rounded to nearest.
  localparam logic [63:0] PI_Q32      = 64'd13493037705;
  localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
  localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;

  typedef enum logic {
    OP_COSINE = 1'b0,
    OP_SINE   = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ===== design/cstu_in_if.sv =====
// Input channel carrying one angle and the operation wanted.
`default_nettype none

interface cstu_in_if
  import cstu_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  op_t                       operation;

  modport source (output valid, output angle, output operation, input ready);
  modport sink   (input valid, input angle, input operation, output ready);
endinterface

`default_nettype wire

// ===== design/cstu_out_if.sv =====
// Result channel carrying one Q2.30 cosine or sine value.
`default_nettype none

interface cstu_out_if
  import cstu_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== design/cosine_sine_taylor_unit.sv =====
// Pipelined fixed-point cosine and sine by a truncated odd Taylor series.
// Throughput: one transaction per cycle while the output is not stalled; each modulo
// step and each series term has stages of its own, and every stage holds its item
// until the next one frees up.
// Reset clears only the stage valid bits; data registers are not reset.
`default_nettype none

module cosine_sine_taylor_unit
  import cstu_pkg::*;
#(
  parameter int SERIES_TERMS        = 5,
  parameter int ANGLE_FRACTION_BITS = 24
) (
  input  wire         clk,
  input  wire         rst_n,
  cstu_in_if.sink     in_ch,
  cstu_out_if.source  out_ch
);

  localparam int SHIFT = 32 - ANGLE_FRACTION_BITS;
  localparam int TW    = 32 + SHIFT;
  localparam int QB    = TW - 34;
  localparam int NT    = SERIES_TERMS - 1;
  localparam int S_PI  = 2 + QB;
  localparam int S_U   = S_PI + 1;
  localparam int S_W2  = S_U + 1;
  localparam int NS    = S_W2 + 3 * NT + 1;

  typedef struct packed {
    logic [TW-1:0]             t;
    logic                      eq;
    logic                      neg;
    logic                      sneg;
    logic [30:0]               w;
    logic [31:0]               w2;
    logic [31:0]               term;
    logic [32:0]               p;
    logic [30:0]               q0;
    logic signed [33:0]        sum;
    logic signed [VALUE_W-1:0] value;
  } stage_t;

  stage_t      pipe_r   [NS:1];
  stage_t      pipe_nxt [NS:1];
  logic [NS:1]   vld_r;
  logic [NS:0]   vld_chain;
  logic [NS+1:1] en;

  assign vld_chain  = {vld_r, in_ch.valid};
  assign en[NS+1]   = out_ch.ready;
  assign in_ch.ready  = en[1];
  assign out_ch.valid = vld_r[NS];
  assign out_ch.value = pipe_r[NS].value;

  for (genvar s = 1; s <= NS; s++) begin : gen_en
    assign en[s] = !vld_r[s] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 1; s <= NS; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_chain[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 1; s <= NS; s++) begin
      if (en[s]) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  // Widen the angle to 32 fraction bits, fold sine onto cosine, take magnitude.
  always_comb begin
    logic signed [TW:0] ang_ext;
    logic signed [TW:0] xa;
    pipe_nxt[1] = '0;
    ang_ext = {{(TW-31){in_ch.angle[ANGLE_W-1]}}, in_ch.angle};
    xa = ang_ext <<< SHIFT;
    if (in_ch.operation == OP_SINE) begin
      xa = signed'((TW+1)'(HALF_PI_Q32)) - xa;
    end
    pipe_nxt[1].t  = xa[TW] ? TW'(-xa) : TW'(xa);
    pipe_nxt[1].eq = (pipe_nxt[1].t == TW'(TWO_PI_Q32));
  end

  // Restoring reduction modulo 2pi, one quotient bit per stage.
  for (genvar j = 0; j < QB; j++) begin : gen_mod
    localparam int K = QB - 1 - j;
    localparam logic [TW-1:0] THR = TW'(TWO_PI_Q32) << K;
    always_comb begin
      logic take;
      pipe_nxt[2+j] = pipe_r[1+j];
      take = (pipe_r[1+j].t >= THR) && !((K == 0) && pipe_r[1+j].eq);
      if (take) begin
        pipe_nxt[2+j].t = pipe_r[1+j].t - THR;
      end
    end
  end

  always_comb begin
    pipe_nxt[S_PI] = pipe_r[S_PI-1];
    if (pipe_r[S_PI-1].t > TW'(PI_Q32)) begin
      pipe_nxt[S_PI].t   = pipe_r[S_PI-1].t - TW'(PI_Q32);
      pipe_nxt[S_PI].neg = 1'b1;
    end
  end

  always_comb begin
    logic signed [35:0] u;
    logic [35:0]        mag;
    pipe_nxt[S_U] = pipe_r[S_U-1];
    u   = signed'({1'b0, pipe_r[S_U-1].t[34:0]}) - signed'(36'(HALF_PI_Q32));
    mag = u[35] ? 36'(-u) : 36'(u);
    pipe_nxt[S_U].w    = mag[32:2];
    pipe_nxt[S_U].sneg = (!u[35] && (u != '0)) ^ pipe_r[S_U-1].neg;
  end

  always_comb begin
    logic [61:0] sq;
    pipe_nxt[S_W2] = pipe_r[S_W2-1];
    sq = 62'(pipe_r[S_W2-1].w) * 62'(pipe_r[S_W2-1].w);
    pipe_nxt[S_W2].w2   = sq[61:30];
    pipe_nxt[S_W2].term = {1'b0, pipe_r[S_W2-1].w};
    pipe_nxt[S_W2].sum  = signed'({3'b000, pipe_r[S_W2-1].w});
  end

  // Each series term: multiply by w2, divide by the factorial step through a
  // reciprocal, then correct the quotient by one and accumulate.
  for (genvar k = 1; k <= NT; k++) begin : gen_term
    localparam int SA = S_W2 + 3 * k - 2;
    localparam int DIV = (2 * k) * (2 * k + 1);
    localparam logic [30:0] RECIP = 31'((64'd1 << 33) / DIV);

    always_comb begin
      logic [63:0] prod;
      pipe_nxt[SA] = pipe_r[SA-1];
      prod = 64'(pipe_r[SA-1].term) * 64'(pipe_r[SA-1].w2);
      pipe_nxt[SA].p = prod[62:30];
    end

    always_comb begin
      logic [63:0] prod;
      pipe_nxt[SA+1] = pipe_r[SA];
      prod = 64'(pipe_r[SA].p) * 64'(RECIP);
      pipe_nxt[SA+1].q0 = prod[63:33];
    end

    always_comb begin
      logic [32:0] rem;
      logic [31:0] q;
      pipe_nxt[SA+2] = pipe_r[SA+1];
      rem = pipe_r[SA+1].p - 33'(pipe_r[SA+1].q0) * 33'(DIV);
      q   = (rem >= 33'(DIV)) ? 32'(pipe_r[SA+1].q0) + 32'd1 : 32'(pipe_r[SA+1].q0);
      pipe_nxt[SA+2].term = q;
      if (k % 2 == 1) begin
        pipe_nxt[SA+2].sum = pipe_r[SA+1].sum - signed'({2'b00, q});
      end else begin
        pipe_nxt[SA+2].sum = pipe_r[SA+1].sum + signed'({2'b00, q});
      end
    end
  end

  always_comb begin
    logic signed [34:0] rs;
    pipe_nxt[NS] = pipe_r[NS-1];
    rs = pipe_r[NS-1].sneg ? -35'(pipe_r[NS-1].sum) : 35'(pipe_r[NS-1].sum);
    if (rs > 35'sd2147483647) begin
      pipe_nxt[NS].value = 32'sh7FFF_FFFF;
    end else if (rs < -35'sd2147483648) begin
      pipe_nxt[NS].value = 32'sh8000_0000;
    end else begin
      pipe_nxt[NS].value = rs[31:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/cstu_checker.sv =====
// Port-level checker for the cosine and sine unit and its bind statement.
`default_nettype none
`include "cosine_sine_taylor_unit_assert.svh"

module cstu_checker
  import cstu_pkg::*;
(
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire signed [VALUE_W-1:0] out_value
);

  logic [15:0] pend_r;
  logic [15:0] pend_nxt;
  logic        out_stall;

  assign pend_nxt = pend_r + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
  assign out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A result may only appear for a transaction that is still outstanding.
  `CSTU_ASSERT_SAME(a_no_spurious_out, clk, rst_n, out_valid, pend_r != 16'd0, "orphan result")
  // With the output free, the pipeline must take a new transaction.
  `CSTU_ASSERT_SAME(a_ready_when_free, clk, rst_n, !out_valid || out_ready, in_ready, "input held")
  `CSTU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_value), "unstable")

endmodule

bind cosine_sine_taylor_unit cstu_checker u_cstu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);

`default_nettype wire
